[rtl/core/pffha_pkg.sv]
// ----------------------------------------------------------------------------
// pffha_pkg
// shared constants, command codes and status flags of the paged heap allocator
// ----------------------------------------------------------------------------
package pffha_pkg;

  // heap geometry
  localparam int MAX_PAGES      = 8;
  localparam int MAX_BLOCKS     = 32;
  localparam int PAGE_BYTES_MAX = 4096;
  localparam int HDR_BYTES      = 5;
  localparam int MARGIN_BYTES   = 10;
  localparam int MIN_PAGE_BYTES = 16;

  // derived widths
  localparam int PAGE_W = $clog2(MAX_PAGES);
  localparam int PCNT_W = $clog2(MAX_PAGES + 1);
  localparam int BLK_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int LIM_W  = (PCNT_W > 4) ? PCNT_W : 4;
  localparam int AW     = PAGE_W + BLK_W;

  // field widths
  localparam int PS_W   = 13;
  localparam int BASE_W = 10;
  localparam int MAXP_W = 4;
  localparam int SIZE_W = 12;
  localparam int ADDR_W = 23;
  localparam int FREE_W = 13;
  localparam int MUL_W  = 24;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TOOBIG  = 2'd1,
    ST_NOPAGE  = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  // operation codes
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PAGE_SIZE = 2'd0,
    REG_BASE_PAGE = 2'd1,
    REG_MAX_PAGES = 2'd2
  } reg_idx_t;

  // datapath commands
  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_TOOBIG, CMD_NOPAGE, CMD_BADFREE, CMD_PAGE_NEXT,
    CMD_WALK_INIT, CMD_RD_B, CMD_SKIP, CMD_TAKE_SZ, CMD_OPEN, CMD_USE_WHOLE,
    CMD_SHR_INIT, CMD_RD_IM1, CMD_WR_I_DEC, CMD_SPLIT1, CMD_SPLIT2, CMD_MUL,
    CMD_ADDR, CMD_DIV_STEP, CMD_FSLOT, CMD_FREE_B, CMD_MERGE_NEXT, CMD_RD_PREV,
    CMD_MERGE_PREV, CMD_RD_IP1, CMD_WR_I_INC, CMD_CNT_DEC, CMD_RD_0,
    CMD_RELEASE, CMD_EMIT
  } cmd_t;

  // datapath status flags
  typedef struct packed {
    logic too_big;
    logic page_done;
    logic page_cand;
    logic blk_end;
    logic fit;
    logic split_ok;
    logic shr_more;
    logic open_found;
    logic div_done;
    logic slot_ok;
    logic off_hit;
    logic rd_free;
    logic has_next;
    logic has_prev;
    logic shl_more;
    logic cnt_one;
  } dp_stat_t;

endpackage

[rtl/core/pffha_dp.sv]
// ----------------------------------------------------------------------------
// pffha_dp
// block table memory, page bookkeeping, divider and address arithmetic
// ----------------------------------------------------------------------------
module pffha_dp
  import pffha_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output dp_stat_t             stat,
  input  logic [PS_W-1:0]      ps,
  input  logic [BASE_W-1:0]    base,
  input  logic [LIM_W-1:0]     lim,
  input  logic                 in_op,
  input  logic [SIZE_W-1:0]    in_req,
  input  logic [ADDR_W-1:0]    in_fa,
  output logic [1:0]           out_status,
  output logic [ADDR_W-1:0]    out_address,
  output logic                 out_opened,
  output logic                 out_released
);

  // block table: bit 12 free flag, bits 11..0 payload size
  logic [SIZE_W:0]      mem [MAX_PAGES*MAX_BLOCKS];
  logic [SIZE_W:0]      rdata;

  // page bookkeeping
  logic [CNT_W-1:0]     blk_cnt [MAX_PAGES];
  logic                 act [MAX_PAGES];
  logic [FREE_W-1:0]    fbytes [MAX_PAGES];

  // working registers
  logic                 op_r;
  logic [SIZE_W-1:0]    req;
  logic [PCNT_W-1:0]    p;
  logic [CNT_W-1:0]     b;
  logic [CNT_W-1:0]     i;
  logic [PS_W-1:0]      start;
  logic [SIZE_W-1:0]    sz;
  logic [PS_W-1:0]      rem;
  logic [ADDR_W-1:0]    dq;
  logic [4:0]           kcnt;
  logic [MUL_W-1:0]     mul;
  logic [1:0]           status;
  logic [ADDR_W-1:0]    addr;
  logic                 opened;
  logic                 released;

  // combinational helpers
  logic [PAGE_W-1:0]    pidx;
  logic [SIZE_W-1:0]    rsize;
  logic [CNT_W-1:0]     b1;
  logic [CNT_W-1:0]     bm1;
  logic [CNT_W-1:0]     cur_cnt;
  logic [PAGE_W-1:0]    osl;
  logic                 ofound;
  logic [ADDR_W-1:0]    slot_diff;
  logic [PS_W:0]        trial;
  logic                 ge;
  logic [SIZE_W-1:0]    sz_nx;
  logic [SIZE_W-1:0]    sz_pv;
  logic [SIZE_W-1:0]    ps_m5;
  logic                 we;
  logic [PAGE_W-1:0]    wpage;
  logic [BLK_W-1:0]     wblk;
  logic [SIZE_W:0]      wdata;
  logic [BLK_W-1:0]     rblk;

  assign pidx    = p[PAGE_W-1:0];
  assign rsize   = rdata[SIZE_W-1:0];
  assign b1      = b + CNT_W'(1);
  assign bm1     = b - CNT_W'(1);
  assign cur_cnt = blk_cnt[pidx];
  assign sz_nx   = sz + rsize + SIZE_W'(HDR_BYTES);
  assign sz_pv   = rsize + sz + SIZE_W'(HDR_BYTES);
  assign ps_m5   = SIZE_W'(ps - PS_W'(HDR_BYTES));
  assign slot_diff = dq - ADDR_W'(base);
  assign trial   = {rem, dq[ADDR_W-1]};
  assign ge      = trial >= {1'b0, ps};

  // lowest closed slot below the page limit
  always_comb begin
    ofound = 1'b0;
    osl    = '0;
    for (int j = MAX_PAGES - 1; j >= 0; j--) begin
      if (!act[j] && (LIM_W'(j) < lim)) begin
        ofound = 1'b1;
        osl    = PAGE_W'(j);
      end
    end
  end

  // status flags to the controller
  always_comb begin
    stat.too_big    = ({1'b0, req} + PS_W'(MARGIN_BYTES)) >= ps;
    stat.page_done  = p == PCNT_W'(MAX_PAGES);
    stat.page_cand  = act[pidx] && (fbytes[pidx] >= ({1'b0, req} + FREE_W'(HDR_BYTES)));
    stat.blk_end    = b == cur_cnt;
    stat.fit        = rdata[SIZE_W] && (rsize >= req);
    stat.split_ok   = ((sz - req) > SIZE_W'(HDR_BYTES)) && (cur_cnt < CNT_W'(MAX_BLOCKS));
    stat.shr_more   = {1'b0, i} > ({1'b0, b} + (CNT_W+1)'(1));
    stat.open_found = ofound;
    stat.div_done   = kcnt == 5'd0;
    stat.slot_ok    = (dq >= ADDR_W'(base)) && (slot_diff < ADDR_W'(MAX_PAGES))
                      && act[slot_diff[PAGE_W-1:0]];
    stat.off_hit    = ({1'b0, start} + (PS_W+1)'(HDR_BYTES)) == {1'b0, rem};
    stat.rd_free    = rdata[SIZE_W];
    stat.has_next   = {1'b0, b} + (CNT_W+1)'(1) < {1'b0, cur_cnt};
    stat.has_prev   = b != '0;
    stat.shl_more   = {1'b0, i} + (CNT_W+1)'(1) < {1'b0, cur_cnt};
    stat.cnt_one    = cur_cnt == CNT_W'(1);
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    wpage = pidx;
    wblk  = b[BLK_W-1:0];
    wdata = '0;
    rblk  = b[BLK_W-1:0];
    unique case (cmd)
      CMD_OPEN: begin
        we    = 1'b1;
        wpage = osl;
        wblk  = '0;
        wdata = {1'b1, ps_m5};
      end
      CMD_USE_WHOLE: begin
        we    = 1'b1;
        wdata = {1'b0, sz};
      end
      CMD_SPLIT1: begin
        we    = 1'b1;
        wdata = {1'b0, req};
      end
      CMD_SPLIT2: begin
        we    = 1'b1;
        wblk  = b1[BLK_W-1:0];
        wdata = {1'b1, SIZE_W'(sz - req - SIZE_W'(HDR_BYTES))};
      end
      CMD_WR_I_DEC, CMD_WR_I_INC: begin
        we    = 1'b1;
        wblk  = i[BLK_W-1:0];
        wdata = rdata;
      end
      CMD_FREE_B: begin
        we    = 1'b1;
        wdata = {1'b1, rsize};
        rblk  = b1[BLK_W-1:0];
      end
      CMD_MERGE_NEXT: begin
        we    = 1'b1;
        wdata = {1'b1, sz_nx};
      end
      CMD_MERGE_PREV: begin
        we    = 1'b1;
        wblk  = bm1[BLK_W-1:0];
        wdata = {1'b1, sz_pv};
      end
      CMD_RD_IM1:  rblk = BLK_W'(i - CNT_W'(1));
      CMD_RD_IP1:  rblk = BLK_W'(i + CNT_W'(1));
      CMD_RD_PREV: rblk = bm1[BLK_W-1:0];
      CMD_RD_0:    rblk = '0;
      default: ;
    endcase
  end

  // block table memory, registered read
  always_ff @(posedge clk) begin
    if (we) mem[{wpage, wblk}] <= wdata;
    rdata <= mem[{pidx, rblk}];
  end

  // page bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_PAGES; j++) begin
        blk_cnt[j] <= '0;
        act[j]     <= 1'b0;
        fbytes[j]  <= '0;
      end
    end else begin
      unique case (cmd)
        CMD_OPEN: begin
          act[osl]     <= 1'b1;
          blk_cnt[osl] <= CNT_W'(1);
          fbytes[osl]  <= FREE_W'(ps_m5);
        end
        CMD_USE_WHOLE:  fbytes[pidx] <= fbytes[pidx] - FREE_W'(sz);
        CMD_SPLIT2: begin
          blk_cnt[pidx] <= cur_cnt + CNT_W'(1);
          fbytes[pidx]  <= fbytes[pidx] - FREE_W'(req) - FREE_W'(HDR_BYTES);
        end
        CMD_FREE_B:     fbytes[pidx] <= fbytes[pidx] + FREE_W'(rsize);
        CMD_MERGE_NEXT, CMD_MERGE_PREV:
                        fbytes[pidx] <= fbytes[pidx] + FREE_W'(HDR_BYTES);
        CMD_CNT_DEC:    blk_cnt[pidx] <= cur_cnt - CNT_W'(1);
        CMD_RELEASE: begin
          act[pidx]     <= 1'b0;
          blk_cnt[pidx] <= '0;
          fbytes[pidx]  <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        op_r     <= in_op;
        req      <= in_req;
        dq       <= in_fa;
        rem      <= '0;
        kcnt     <= 5'(ADDR_W);
        p        <= '0;
        status   <= ST_OK;
        addr     <= '0;
        opened   <= 1'b0;
        released <= 1'b0;
      end
      CMD_TOOBIG:    status <= ST_TOOBIG;
      CMD_NOPAGE:    status <= ST_NOPAGE;
      CMD_BADFREE:   status <= ST_BADFREE;
      CMD_PAGE_NEXT: p <= p + PCNT_W'(1);
      CMD_WALK_INIT: begin
        b     <= '0;
        start <= '0;
      end
      CMD_SKIP: begin
        start <= start + PS_W'(rsize) + PS_W'(HDR_BYTES);
        b     <= b1;
      end
      CMD_TAKE_SZ:   sz <= rsize;
      CMD_OPEN: begin
        p      <= PCNT_W'(osl);
        b      <= '0;
        start  <= '0;
        sz     <= ps_m5;
        opened <= 1'b1;
      end
      CMD_SHR_INIT:  i <= cur_cnt;
      CMD_WR_I_DEC:  i <= i - CNT_W'(1);
      CMD_WR_I_INC:  i <= i + CNT_W'(1);
      CMD_MUL:       mul <= (MUL_W'(base) + MUL_W'(pidx)) * MUL_W'(ps);
      CMD_ADDR:      addr <= ADDR_W'(mul + MUL_W'(start) + MUL_W'(HDR_BYTES));
      CMD_DIV_STEP: begin
        rem  <= ge ? PS_W'(trial - {1'b0, ps}) : trial[PS_W-1:0];
        dq   <= {dq[ADDR_W-2:0], ge};
        kcnt <= kcnt - 5'd1;
      end
      CMD_FSLOT: begin
        p     <= PCNT_W'(slot_diff);
        b     <= '0;
        start <= '0;
      end
      CMD_FREE_B:    sz <= rsize;
      CMD_MERGE_NEXT: begin
        sz <= sz_nx;
        i  <= b1;
      end
      CMD_MERGE_PREV: i <= b;
      CMD_RELEASE:   released <= 1'b1;
      CMD_EMIT: begin
        out_status   <= status;
        out_address  <= addr;
        out_opened   <= opened & (op_r == OP_ALLOC);
        out_released <= released;
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/pffha_ctrl.sv]
// ----------------------------------------------------------------------------
// pffha_ctrl
// sequencer for allocate and free walks, input and result handshakes
// ----------------------------------------------------------------------------
module pffha_ctrl
  import pffha_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  logic     op,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  typedef enum logic [24:0] {
    S_IDLE   = 25'd1 << 0,
    S_A_CHK  = 25'd1 << 1,
    S_A_PAGE = 25'd1 << 2,
    S_A_RD   = 25'd1 << 3,
    S_A_EVAL = 25'd1 << 4,
    S_A_FIT  = 25'd1 << 5,
    S_A_SHR  = 25'd1 << 6,
    S_A_SHW  = 25'd1 << 7,
    S_A_SPL2 = 25'd1 << 8,
    S_A_OPEN = 25'd1 << 9,
    S_A_ADDR = 25'd1 << 10,
    S_A_ADR2 = 25'd1 << 11,
    S_F_DIV  = 25'd1 << 12,
    S_F_CHK  = 25'd1 << 13,
    S_F_RD   = 25'd1 << 14,
    S_F_SKIP = 25'd1 << 15,
    S_F_HIT  = 25'd1 << 16,
    S_F_NXT  = 25'd1 << 17,
    S_F_PRV  = 25'd1 << 18,
    S_F_PRV2 = 25'd1 << 19,
    S_F_REL  = 25'd1 << 20,
    S_F_REL2 = 25'd1 << 21,
    S_R_CHK  = 25'd1 << 22,
    S_R_WR   = 25'd1 << 23,
    S_DONE   = 25'd1 << 24
  } state_t;

  state_t state, state_next;
  logic   prev_pass, prev_pass_next;

  assign s_tready = state == S_IDLE;

  // next state and command
  always_comb begin
    state_next     = state;
    prev_pass_next = prev_pass;
    cmd            = CMD_NONE;
    unique case (state)
      S_IDLE: if (s_tvalid) begin
        cmd        = CMD_LOAD;
        state_next = (op == OP_FREE) ? S_F_DIV : S_A_CHK;
      end
      S_A_CHK: begin
        if (stat.too_big) begin
          cmd        = CMD_TOOBIG;
          state_next = S_DONE;
        end else begin
          state_next = S_A_PAGE;
        end
      end
      S_A_PAGE: begin
        priority if (stat.page_done) begin
          state_next = S_A_OPEN;
        end else if (stat.page_cand) begin
          cmd        = CMD_WALK_INIT;
          state_next = S_A_RD;
        end else begin
          cmd = CMD_PAGE_NEXT;
        end
      end
      S_A_RD: begin
        if (stat.blk_end) begin
          cmd        = CMD_PAGE_NEXT;
          state_next = S_A_PAGE;
        end else begin
          cmd        = CMD_RD_B;
          state_next = S_A_EVAL;
        end
      end
      S_A_EVAL: begin
        if (stat.fit) begin
          cmd        = CMD_TAKE_SZ;
          state_next = S_A_FIT;
        end else begin
          cmd        = CMD_SKIP;
          state_next = S_A_RD;
        end
      end
      S_A_FIT: begin
        if (stat.split_ok) begin
          cmd        = CMD_SHR_INIT;
          state_next = S_A_SHR;
        end else begin
          cmd        = CMD_USE_WHOLE;
          state_next = S_A_ADDR;
        end
      end
      S_A_SHR: begin
        if (stat.shr_more) begin
          cmd        = CMD_RD_IM1;
          state_next = S_A_SHW;
        end else begin
          cmd        = CMD_SPLIT1;
          state_next = S_A_SPL2;
        end
      end
      S_A_SHW: begin
        cmd        = CMD_WR_I_DEC;
        state_next = S_A_SHR;
      end
      S_A_SPL2: begin
        cmd        = CMD_SPLIT2;
        state_next = S_A_ADDR;
      end
      S_A_OPEN: begin
        if (stat.open_found) begin
          cmd        = CMD_OPEN;
          state_next = S_A_FIT;
        end else begin
          cmd        = CMD_NOPAGE;
          state_next = S_DONE;
        end
      end
      S_A_ADDR: begin
        cmd        = CMD_MUL;
        state_next = S_A_ADR2;
      end
      S_A_ADR2: begin
        cmd        = CMD_ADDR;
        state_next = S_DONE;
      end
      S_F_DIV: begin
        if (stat.div_done) state_next = S_F_CHK;
        else cmd = CMD_DIV_STEP;
      end
      S_F_CHK: begin
        if (stat.slot_ok) begin
          cmd        = CMD_FSLOT;
          state_next = S_F_RD;
        end else begin
          cmd        = CMD_BADFREE;
          state_next = S_DONE;
        end
      end
      S_F_RD: begin
        if (stat.blk_end) begin
          cmd        = CMD_BADFREE;
          state_next = S_DONE;
        end else begin
          cmd        = CMD_RD_B;
          state_next = stat.off_hit ? S_F_HIT : S_F_SKIP;
        end
      end
      S_F_SKIP: begin
        cmd        = CMD_SKIP;
        state_next = S_F_RD;
      end
      S_F_HIT: begin
        if (stat.rd_free) begin
          cmd        = CMD_BADFREE;
          state_next = S_DONE;
        end else begin
          cmd        = CMD_FREE_B;
          state_next = stat.has_next ? S_F_NXT : S_F_PRV;
        end
      end
      S_F_NXT: begin
        if (stat.rd_free) begin
          cmd            = CMD_MERGE_NEXT;
          prev_pass_next = 1'b0;
          state_next     = S_R_CHK;
        end else begin
          state_next = S_F_PRV;
        end
      end
      S_F_PRV: begin
        if (stat.has_prev) begin
          cmd        = CMD_RD_PREV;
          state_next = S_F_PRV2;
        end else begin
          state_next = S_F_REL;
        end
      end
      S_F_PRV2: begin
        if (stat.rd_free) begin
          cmd            = CMD_MERGE_PREV;
          prev_pass_next = 1'b1;
          state_next     = S_R_CHK;
        end else begin
          state_next = S_F_REL;
        end
      end
      S_F_REL: begin
        if (stat.cnt_one) begin
          cmd        = CMD_RD_0;
          state_next = S_F_REL2;
        end else begin
          state_next = S_DONE;
        end
      end
      S_F_REL2: begin
        if (stat.rd_free) cmd = CMD_RELEASE;
        state_next = S_DONE;
      end
      // close the gap left by a merged entry
      S_R_CHK: begin
        if (stat.shl_more) begin
          cmd        = CMD_RD_IP1;
          state_next = S_R_WR;
        end else begin
          cmd        = CMD_CNT_DEC;
          state_next = prev_pass ? S_F_REL : S_F_PRV;
        end
      end
      S_R_WR: begin
        cmd        = CMD_WR_I_INC;
        state_next = S_R_CHK;
      end
      S_DONE: if (!m_tvalid || m_tready) begin
        cmd        = CMD_EMIT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prev_pass <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      prev_pass <= prev_pass_next;
      if (cmd == CMD_EMIT) m_tvalid <= 1'b1;
      else if (m_tready)   m_tvalid <= 1'b0;
    end
  end

endmodule

[rtl/core/paged_first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// paged_first_fit_heap_allocator
// first-fit heap over paged memory with in-page block headers
// ----------------------------------------------------------------------------
// channel   direction  signals                          transfer when
// s_*       in         s_tdata, s_tuser                 s_tvalid & s_tready
// m_*       out        m_tdata, m_tuser                 m_tvalid & m_tready
// apb       in         psel penable pwrite paddr pwdata psel & penable & pwrite
//
// one request at a time; the block table is a memory with one write port and
// one registered read port. allocate: size check, page slots passed over,
// headers read, entries moved on split.
// free: load, bit-serial offset divider and slot check, then headers walked
// and entries moved on each merge.
// reset clears page state at once.
// a result waiting in the output register does not block the next request.
// ----------------------------------------------------------------------------
module paged_first_fit_heap_allocator
  import pffha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // request_size[11:0], free_address[34:12], zero pad
  input  logic        s_tuser,   // operation[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // address[22:0], page_opened[23], page_released[24]
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [PS_W-1:0]   page_size;
  logic [BASE_W-1:0] base_page;
  logic [MAXP_W-1:0] max_pages;
  logic [PS_W-1:0]   ps_eff;
  logic [LIM_W-1:0]  lim;
  reg_idx_t          ridx;
  cmd_t              cmd;
  dp_stat_t          stat;
  logic [1:0]        res_status;
  logic [ADDR_W-1:0] res_address;
  logic              res_opened;
  logic              res_released;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_size <= PS_W'(256);
      base_page <= '0;
      max_pages <= MAXP_W'(8);
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_PAGE_SIZE: page_size <= pwdata[PS_W-1:0];
        REG_BASE_PAGE: base_page <= pwdata[BASE_W-1:0];
        REG_MAX_PAGES: max_pages <= pwdata[MAXP_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (ridx)
      REG_PAGE_SIZE: prdata = 32'(page_size);
      REG_BASE_PAGE: prdata = 32'(base_page);
      REG_MAX_PAGES: prdata = 32'(max_pages);
      default:       prdata = '0;
    endcase
  end

  // clamped page size and page limit
  always_comb begin
    priority if (page_size < PS_W'(MIN_PAGE_BYTES)) ps_eff = PS_W'(MIN_PAGE_BYTES);
    else if (page_size > PS_W'(PAGE_BYTES_MAX))     ps_eff = PS_W'(PAGE_BYTES_MAX);
    else                                            ps_eff = page_size;
    if (LIM_W'(max_pages) > LIM_W'(MAX_PAGES)) lim = LIM_W'(MAX_PAGES);
    else                                       lim = LIM_W'(max_pages);
  end

  pffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pffha_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .ps           (ps_eff),
    .base         (base_page),
    .lim          (lim),
    .in_op        (s_tuser),
    .in_req       (s_tdata[11:0]),
    .in_fa        (s_tdata[34:12]),
    .out_status   (res_status),
    .out_address  (res_address),
    .out_opened   (res_opened),
    .out_released (res_released)
  );

  assign m_tuser = res_status;
  assign m_tdata = {7'd0, res_released, res_opened, res_address};

  // no new request is taken while one is in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

  // oversized allocations and bad frees return no address
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_TOOBIG || m_tuser == ST_BADFREE) |-> m_tdata[22:0] == '0)
    else $error("failure carries an address");

  // a page cannot be opened and released by the same request
  a_open_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[23] && m_tdata[24]))
    else $error("page opened and released together");

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// checks the paged first-fit heap allocator: a behavioral heap tracks pages,
// block headers and free bytes, and each result is compared with it
// ----------------------------------------------------------------------------
module tb;
  import pffha_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t     status;
    logic [22:0] address;
    logic        opened;
    logic        released;
  } heap_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // request_size[11:0], free_address[34:12], zero pad
  logic        s_tuser = 1'b0;  // operation[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;  // address[22:0], page_opened[23], page_released[24]
  logic [1:0]  m_tuser;  // status[1:0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  paged_first_fit_heap_allocator u_dut (.*);

  always #4 clk = ~clk;

  // heap mirror
  logic [12:0] blk_tab [MAX_PAGES][MAX_BLOCKS];
  int          blk_cnt [MAX_PAGES];
  bit          pg_on [MAX_PAGES];
  int          pg_free [MAX_PAGES];
  int          cfg_ps = 256;
  int          cfg_base = 0;
  int          cfg_maxp = 8;

  heap_result_t expected_q[$];
  int errs = 0;
  int send_idle = 0;
  int recv_idle = 0;

  function automatic int page_bytes();
    if (cfg_ps < MIN_PAGE_BYTES) return MIN_PAGE_BYTES;
    if (cfg_ps > PAGE_BYTES_MAX) return PAGE_BYTES_MAX;
    return cfg_ps;
  endfunction

  function automatic void take_free(int p, int v);
    pg_free[p] = (pg_free[p] > v) ? pg_free[p] - v : 0;
  endfunction

  // first fit inside one page, splitting when the rest is larger than a header and the table has room
  function automatic bit place_in_page(int p, int req, output int start);
    int sz;
    start = 0;
    for (int b = 0; b < blk_cnt[p]; b++) begin
      sz = blk_tab[p][b][11:0];
      if (blk_tab[p][b][12] && sz >= req) begin
        if (sz - req > HDR_BYTES && blk_cnt[p] < MAX_BLOCKS) begin
          for (int i = blk_cnt[p]; i > b + 1; i--) blk_tab[p][i] = blk_tab[p][i-1];
          blk_tab[p][b] = {1'b0, 12'(req)};
          blk_tab[p][b+1] = {1'b1, 12'(sz - req - HDR_BYTES)};
          blk_cnt[p]++;
          take_free(p, req + HDR_BYTES);
        end else begin
          blk_tab[p][b][12] = 1'b0;
          take_free(p, sz);
        end
        return 1'b1;
      end
      start += sz + HDR_BYTES;
    end
    return 1'b0;
  endfunction

  function automatic void drop_entry(int p, int b);
    for (int i = b; i + 1 < blk_cnt[p]; i++) blk_tab[p][i] = blk_tab[p][i+1];
    blk_cnt[p]--;
  endfunction

  function automatic heap_result_t heap_alloc(int req);
    heap_result_t r;
    int ps, start, slot, lim, p;
    bit placed;
    ps = page_bytes();
    r = '{ST_OK, '0, 1'b0, 1'b0};
    placed = 1'b0;
    slot = 0;
    start = 0;
    if (req + MARGIN_BYTES >= ps) begin
      r.status = ST_TOOBIG;
      return r;
    end
    for (p = 0; p < MAX_PAGES && !placed; p++)
      if (pg_on[p] && pg_free[p] >= req + HDR_BYTES && place_in_page(p, req, start)) begin
        placed = 1'b1;
        slot = p;
      end
    // open the lowest closed slot
    if (!placed) begin
      lim = (cfg_maxp < MAX_PAGES) ? cfg_maxp : MAX_PAGES;
      for (p = 0; p < lim; p++) if (!pg_on[p]) break;
      if (p >= lim) begin
        r.status = ST_NOPAGE;
      end else begin
        pg_on[p] = 1'b1;
        blk_cnt[p] = 1;
        blk_tab[p][0] = {1'b1, 12'(ps - HDR_BYTES)};
        pg_free[p] = ps - HDR_BYTES;
        r.opened = 1'b1;
        if (place_in_page(p, req, start)) begin
          placed = 1'b1;
          slot = p;
        end else begin
          r.status = ST_NOPAGE;
        end
      end
    end
    if (placed) r.address = 23'((cfg_base + slot) * ps + start + HDR_BYTES);
    return r;
  endfunction

  function automatic heap_result_t heap_free(int fa);
    heap_result_t r;
    int ps, pn, off, slot, start, b;
    bit found;
    ps = page_bytes();
    pn = fa / ps;
    off = fa % ps;
    r = '{ST_BADFREE, '0, 1'b0, 1'b0};
    found = 1'b0;
    start = 0;
    if (pn < cfg_base) return r;
    slot = pn - cfg_base;
    if (slot >= MAX_PAGES || !pg_on[slot]) return r;
    for (b = 0; b < blk_cnt[slot]; b++) begin
      if (start + HDR_BYTES == off) begin
        found = 1'b1;
        break;
      end
      start += blk_tab[slot][b][11:0] + HDR_BYTES;
    end
    if (!found || blk_tab[slot][b][12]) return r;
    r.status = ST_OK;
    blk_tab[slot][b][12] = 1'b1;
    pg_free[slot] += blk_tab[slot][b][11:0];
    // merge with the following block
    if (b + 1 < blk_cnt[slot] && blk_tab[slot][b+1][12]) begin
      blk_tab[slot][b] = {1'b1, 12'(blk_tab[slot][b][11:0] + blk_tab[slot][b+1][11:0]
                                    + HDR_BYTES)};
      pg_free[slot] += HDR_BYTES;
      drop_entry(slot, b + 1);
    end
    // merge with the preceding block
    if (b > 0 && blk_tab[slot][b-1][12]) begin
      blk_tab[slot][b-1] = {1'b1, 12'(blk_tab[slot][b-1][11:0] + blk_tab[slot][b][11:0]
                                      + HDR_BYTES)};
      pg_free[slot] += HDR_BYTES;
      drop_entry(slot, b);
    end
    if (blk_cnt[slot] == 1 && blk_tab[slot][0][12]) begin
      pg_on[slot] = 1'b0;
      blk_cnt[slot] = 0;
      pg_free[slot] = 0;
      r.released = 1'b1;
    end
    return r;
  endfunction

  // user address of a random block, used or free as asked; -1 when none
  function automatic int pick_block_addr(bit want_used);
    int n, k, start, ps;
    ps = page_bytes();
    n = 0;
    for (int p = 0; p < MAX_PAGES; p++)
      if (pg_on[p])
        for (int b = 0; b < blk_cnt[p]; b++) if (blk_tab[p][b][12] != want_used) n++;
    if (n == 0) return -1;
    k = $urandom_range(0, n - 1);
    for (int p = 0; p < MAX_PAGES; p++) begin
      start = 0;
      if (pg_on[p])
        for (int b = 0; b < blk_cnt[p]; b++) begin
          if (blk_tab[p][b][12] != want_used) begin
            if (k == 0) return ((cfg_base + p) * ps + start + HDR_BYTES) & 32'h7FFFFF;
            k--;
          end
          start += blk_tab[p][b][11:0] + HDR_BYTES;
        end
    end
    return -1;
  endfunction

  // one request transfer, with random idle cycles ahead of it
  task automatic send_item(op_t op, int req, int fa);
    if (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {5'b0, 23'(fa), 12'(req)};
    do @(posedge clk); while (!s_tready);
    if (op == OP_ALLOC) expected_q.push_back(heap_alloc(req & 12'hFFF));
    else expected_q.push_back(heap_free(fa & 32'h7FFFFF));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write with setup and access cycles, heap idle
  task automatic write_reg(reg_idx_t idx, int value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PAGE_SIZE: cfg_ps = value & 32'h1FFF;
      REG_BASE_PAGE: cfg_base = value & 32'h3FF;
      default:       cfg_maxp = value & 32'hF;
    endcase
  endtask

  task automatic alloc(int req);
    send_item(OP_ALLOC, req, 0);
  endtask

  task automatic free_used();
    int a;
    a = pick_block_addr(1'b1);
    send_item(OP_FREE, 0, (a < 0) ? 0 : a);
  endtask

  // extremes, bad frees, merges and page release at reset settings
  task automatic test_basic();
    alloc(4095);
    alloc(246);
    alloc(0);
    alloc(245);
    alloc(100);
    alloc(20);
    alloc(30);
    send_item(OP_FREE, 0, 0);
    send_item(OP_FREE, 0, 23'h7FFFFF);
    send_item(OP_FREE, 0, pick_block_addr(1'b1) + 1);
    free_used();
    send_item(OP_FREE, 0, pick_block_addr(1'b0));
    repeat (6) free_used();
  endtask

  // a page full of one-byte blocks stops splitting
  task automatic test_table_full();
    repeat (34) alloc(1);
    repeat (34) free_used();
  endtask

  // no page may be opened, then one page only, then clamped sizes
  task automatic test_limits();
    write_reg(REG_MAX_PAGES, 0);
    alloc(3);
    write_reg(REG_MAX_PAGES, 1);
    alloc(200);
    alloc(200);
    write_reg(REG_PAGE_SIZE, 8);
    alloc(5);
    alloc(6);
    write_reg(REG_BASE_PAGE, 1023);
    free_used();
    free_used();
    write_reg(REG_PAGE_SIZE, 8191);
    write_reg(REG_MAX_PAGES, 15);
    alloc(4085);
    alloc(4000);
    free_used();
  endtask

  task automatic test_random(int count, int ps, int base, int maxp);
    int k, a;
    write_reg(REG_PAGE_SIZE, ps);
    write_reg(REG_BASE_PAGE, base);
    write_reg(REG_MAX_PAGES, maxp);
    ps = page_bytes();
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain();
      k = $urandom_range(0, 99);
      if (k < 55) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: alloc($urandom_range(0, ps / 16));
          6, 7:             alloc($urandom_range(0, ps / 3));
          8:                alloc($urandom_range(0, ps - 11));
          default:          alloc($urandom_range(0, 4095));
        endcase
      end else if (k < 90) begin
        free_used();
      end else begin
        case ($urandom_range(0, 2))
          0:       send_item(OP_FREE, $urandom_range(0, 4095), $urandom_range(0, 23'h7FFFFF));
          1:       send_item(OP_FREE, 0, pick_block_addr(1'b0));
          default: begin
            a = pick_block_addr(1'b1);
            send_item(OP_FREE, 0, (a < 0) ? 1 : a + $urandom_range(1, 3));
          end
        endcase
      end
    end
  endtask

  // result check and receiver stalls
  always @(posedge clk) begin
    heap_result_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (m_tuser !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, m_tuser);
            errs++;
          end
          if (m_tdata[22:0] !== e.address) begin
            $error("address: expected %0h, got %0h", e.address, m_tdata[22:0]);
            errs++;
          end
          if (m_tdata[23] !== e.opened) begin
            $error("page_opened: expected %0d, got %0d", e.opened, m_tdata[23]);
            errs++;
          end
          if (m_tdata[24] !== e.released) begin
            $error("page_released: expected %0d, got %0d", e.released, m_tdata[24]);
            errs++;
          end
        end
      end
    end
  end

  initial begin
    for (int p = 0; p < MAX_PAGES; p++) begin
      blk_cnt[p] = 0;
      pg_on[p] = 1'b0;
      pg_free[p] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 31;
    recv_idle = 80;
    test_basic();
    test_table_full();
    test_limits();
    test_random(300, 256, 0, 8);
    send_idle = 80;
    recv_idle = 31;
    test_random(300, 16, 1023, 8);
    test_random(250, 4096, 1023, 3);
    send_idle = 0;
    recv_idle = 0;
    test_random(300, 100, 5, 2);
    test_random(300, 1000, 37, 8);
    test_random(300, 300, 0, 1);
    drain();
    repeat (50) @(posedge clk);
    if (errs == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
